>>> hdl/midi_scale_chord_expander_defines.svh
// Assertion macros used by the chord expander back end.
`ifndef MIDI_SCALE_CHORD_EXPANDER_DEFINES_SVH
`define MIDI_SCALE_CHORD_EXPANDER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define MSCE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define MSCE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/msce_pkg.sv
// Types, constants and helper functions of the MIDI scale chord expander.
package msce_pkg;

  // Fixed by the 7-bit note number
  localparam int unsigned NoteCount = 128;

  // Command codes of the incoming message
  localparam logic [1:0] CMD_NOTE_ON  = 2'd0;
  localparam logic [1:0] CMD_NOTE_OFF = 2'd1;

  // Configuration register indexes
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 28;
  localparam logic [CfgIdxW-1:0] CFG_ROOT_OFFSET = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_FOUR_VOICE  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_SCALE_STEPS = 2'd2;

  // Reset values: C root, triad, major scale
  localparam logic [3:0]  ROOT_RESET  = 4'd0;
  localparam logic [27:0] STEPS_RESET = 28'h0B975420;

  localparam logic [6:0] BASE_NOTE = 7'd48;
  localparam logic [6:0] OCTAVE    = 7'd12;
  localparam logic [3:0] DEGREES   = 4'd7;

  typedef struct packed {
    logic [1:0]  command;
    logic [4:0]  channel;
    logic [6:0]  trigger_note;
    logic [6:0]  velocity;
    logic [15:0] sample_position;
  } in_item_t;

  typedef struct packed {
    logic        is_note_on;
    logic [4:0]  out_channel;
    logic [6:0]  out_note;
    logic [6:0]  out_velocity;
    logic [15:0] out_position;
    logic        last_of_chord;
  } out_item_t;

  // One stored chord: voicing flag and four notes (note 3 unused for a triad)
  typedef struct packed {
    logic            four;
    logic [3:0][6:0] notes;
  } chord_t;

  // Entry of the queue between front and back
  typedef struct packed {
    logic        is_on;
    logic [4:0]  channel;
    logic [6:0]  trigger_note;
    logic [6:0]  velocity;
    logic [15:0] sample_position;
    chord_t      chord;
  } queue_item_t;

  // Note mod 7 via multiply by 147/1024; exact for 0..127
  function automatic logic [2:0] msce_mod7(input logic [6:0] x);
    logic [14:0] prod;
    logic [4:0]  quot;
    logic [6:0]  quot_x7;
    prod    = 15'(x) * 15'd147;
    quot    = prod[14:10];
    quot_x7 = 7'({2'b00, quot} * 7'd7);
    return 3'(x - quot_x7);
  endfunction

  // Semitone offset of scale degree k
  function automatic logic [3:0] msce_step(input logic [27:0] steps,
                                           input logic [2:0]  k);
    logic [3:0] s;
    case (k)
      3'd0:    s = steps[3:0];
      3'd1:    s = steps[7:4];
      3'd2:    s = steps[11:8];
      3'd3:    s = steps[15:12];
      3'd4:    s = steps[19:16];
      3'd5:    s = steps[23:20];
      3'd6:    s = steps[27:24];
      default: s = 4'd0;
    endcase
    return s;
  endfunction

endpackage

>>> hdl/msce_front.sv
// Front end: configuration registers, message decode and chord computation.
module msce_front
  import msce_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_data_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output logic                push_o,
  output queue_item_t         push_item_o,
  input  logic                full_i
);

  logic [3:0]  root_q;
  logic        four_q;
  logic [27:0] steps_q;

  // Configuration writes; unknown indexes are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q  <= ROOT_RESET;
      four_q  <= 1'b0;
      steps_q <= STEPS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ROOT_OFFSET: root_q  <= cfg_data_i[3:0];
        CFG_FOUR_VOICE:  four_q  <= cfg_data_i[0];
        CFG_SCALE_STEPS: steps_q <= cfg_data_i[27:0];
        default: ;
      endcase
    end
  end

  // Decode: only note on and note off go on to the back end
  logic accept;
  logic is_on, is_off;

  always_comb begin
    is_on  = 1'b0;
    is_off = 1'b0;
    unique case (in_data_i.command)
      CMD_NOTE_ON:  is_on  = 1'b1;
      CMD_NOTE_OFF: is_off = 1'b1;
      default: ;
    endcase
  end

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign push_o     = accept && (is_on || is_off);

  // Chord notes. With root <= 15 and steps <= 15 the largest sum is 105,
  // and the smallest four-voice note is 36, so 7 bits never clip.
  logic [2:0] deg, idx2, idx4;
  logic [3:0] t2, t4;
  logic       wrap2, wrap4;
  logic [6:0] base, s0, s2, s4, root_note;
  chord_t     chord;

  always_comb begin
    deg   = msce_mod7(in_data_i.trigger_note);
    t2    = {1'b0, deg} + 4'd2;
    t4    = {1'b0, deg} + 4'd4;
    wrap2 = (t2 >= DEGREES);
    wrap4 = (t4 >= DEGREES);
    idx2  = wrap2 ? 3'(t2 - DEGREES) : t2[2:0];
    idx4  = wrap4 ? 3'(t4 - DEGREES) : t4[2:0];
    base  = BASE_NOTE + {3'b000, root_q};
    s0    = {3'b000, msce_step(steps_q, deg)};
    s2    = {3'b000, msce_step(steps_q, idx2)};
    s4    = {3'b000, msce_step(steps_q, idx4)};
    root_note = base + s0;
    chord.four = four_q;
    if (four_q) begin
      chord.notes[0] = root_note - OCTAVE;
      chord.notes[1] = root_note + s4;
      chord.notes[2] = root_note + OCTAVE;
      chord.notes[3] = root_note + OCTAVE + s2;
    end else begin
      chord.notes[0] = root_note;
      chord.notes[1] = base + s2 + (wrap2 ? OCTAVE : 7'd0);
      chord.notes[2] = base + s4 + (wrap4 ? OCTAVE : 7'd0);
      chord.notes[3] = 7'd0;
    end
  end

  always_comb begin
    push_item_o.is_on           = is_on;
    push_item_o.channel         = in_data_i.channel;
    push_item_o.trigger_note    = in_data_i.trigger_note;
    push_item_o.velocity        = in_data_i.velocity;
    push_item_o.sample_position = in_data_i.sample_position;
    push_item_o.chord           = chord;
  end

endmodule

>>> hdl/msce_fifo.sv
// Small queue decoupling the front end from the back end.
module msce_fifo
  import msce_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  queue_item_t item_i,
  input  logic        pop_i,
  output queue_item_t item_o,
  output logic        full_o,
  output logic        empty_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  queue_item_t         slot_q [DEPTH];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     count_q;

  assign full_o  = (count_q == FullCnt);
  assign empty_o = (count_q == '0);
  assign item_o  = slot_q[rd_ptr_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      if (push_i && !pop_i)      count_q <= count_q + 1'b1;
      else if (pop_i && !push_i) count_q <= count_q - 1'b1;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= item_i;
  end

endmodule

>>> hdl/msce_back.sv
// Back end: held-chord store and serial emission of chord notes.
`include "midi_scale_chord_expander_defines.svh"

module msce_back
  import msce_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  queue_item_t pop_item_i,
  input  logic        empty_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]           state_q, state_d;
  logic [NoteCount-1:0] held_q;
  logic [1:0]           k_q;
  queue_item_t          cur_q;
  chord_t               mem_q [NoteCount];
  chord_t               mem_rd_q;
  logic                 out_valid_q;
  out_item_t            out_q;

  logic is_held, mem_we, mem_re, out_free, emit, at_last;
  logic [1:0] last_idx;

  assign pop_o    = (state_q == S_IDLE) && !empty_i;
  assign is_held  = held_q[pop_item_i.trigger_note];
  assign mem_we   = pop_o && pop_item_i.is_on;
  assign mem_re   = pop_o && !pop_item_i.is_on && is_held;
  assign out_free = !out_valid_q || !out_stall_i;
  assign emit     = (state_q == S_EMIT) && out_free;
  assign last_idx = cur_q.chord.four ? 2'd3 : 2'd2;
  assign at_last  = (k_q == last_idx);

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (mem_we)      state_d = S_EMIT;
        else if (mem_re) state_d = S_READ;
      end
      S_READ: state_d = S_EMIT;
      S_EMIT: begin
        if (emit && at_last) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      held_q      <= '0;
      k_q         <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (mem_we) held_q[pop_item_i.trigger_note] <= 1'b1;
      if (mem_re) held_q[pop_item_i.trigger_note] <= 1'b0;
      if (pop_o)     k_q <= 2'd0;
      else if (emit) k_q <= k_q + 2'd1;
      if (emit)              out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // Chord store: one write or one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[pop_item_i.trigger_note] <= pop_item_i.chord;
    if (mem_re) mem_rd_q <= mem_q[pop_item_i.trigger_note];
  end

  // Current transaction; a note off takes its notes from the store
  always_ff @(posedge clk_i) begin
    if (pop_o) cur_q <= pop_item_i;
    else if (state_q == S_READ) cur_q.chord <= mem_rd_q;
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q.is_note_on    <= cur_q.is_on;
      out_q.out_channel   <= cur_q.channel;
      out_q.out_note      <= cur_q.chord.notes[k_q];
      out_q.out_velocity  <= cur_q.velocity;
      out_q.out_position  <= cur_q.sample_position;
      out_q.last_of_chord <= at_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `MSCE_ASSERT_NEXT(a_on_sets_held, mem_we, held_q[$past(pop_item_i.trigger_note)], "note on left entry free")
  `MSCE_ASSERT_NEXT(a_off_clears_held, mem_re, !held_q[$past(pop_item_i.trigger_note)], "note off left entry held")
  `MSCE_ASSERT_NEXT(a_read_to_emit, state_q == S_READ, state_q == S_EMIT, "store read not followed by emission")
  `MSCE_ASSERT_NOW(a_no_pop_busy, state_q != S_IDLE, !pop_o, "queue popped while busy")

endmodule

>>> hdl/midi_scale_chord_expander.sv
// MIDI scale chord expander top level.
//
// Input channel (in_valid_i / in_stall_o / in_data_i) takes one MIDI message
// per transaction. A note on yields three (triad) or four (four-voice) note-on
// transactions on the output channel (out_valid_o / out_stall_i / out_data_o);
// a note off of a held trigger note yields the stored chord as note offs.
// last_of_chord marks the final note of each chord. Other messages vanish.
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i; the user
// must write it only while the block is idle, as the block does not enforce it.
// A message is queued, popped by the back end in S_IDLE and its first note is
// loaded into the output register; a note off reads its chord in S_READ first.
// Throughput: the back end dequeues a message only in S_IDLE and then emits one
// note per cycle while the output is not stalled. A queue of QUEUE_DEPTH
// messages lets the input keep accepting while chords are emitted.
// Reset clears configuration to C major triads and marks every note not held.
// A stalled output holds its transaction; the back end then waits and the
// input stalls once the queue is full.
module midi_scale_chord_expander
  import msce_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2  // 2..16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic        push, pop, full, empty;
  queue_item_t push_item, pop_item;

  msce_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .push_o      (push),
    .push_item_o (push_item),
    .full_i      (full)
  );

  msce_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .item_o  (pop_item),
    .full_o  (full),
    .empty_o (empty)
  );

  msce_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_item_i  (pop_item),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> tb/tb.sv
// Self-checking testbench of the MIDI scale chord expander.
module tb;
  import msce_pkg::*;

  // Command codes the package leaves unnamed
  localparam logic [1:0] CMD_OTHER    = 2'd2;
  localparam logic [1:0] CMD_RESERVED = 2'd3;

  // Tracks configuration and held chords, predicts the emitted notes
  class chord_tracker;
    logic [3:0]  root;
    logic        four_mode;
    logic [27:0] steps;
    bit          held [NoteCount];
    bit          held_four [NoteCount];
    logic [6:0]  held_notes [NoteCount][4];
    out_item_t   expected_notes [$];
    int unsigned errors;

    function new();
      root      = ROOT_RESET;
      four_mode = 1'b0;
      steps     = STEPS_RESET;
      errors    = 0;
      foreach (held[i]) begin
        held[i]      = 1'b0;
        held_four[i] = 1'b0;
        for (int k = 0; k < 4; k++) held_notes[i][k] = '0;
      end
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      case (idx)
        CFG_ROOT_OFFSET: root = val[3:0];
        CFG_FOUR_VOICE:  four_mode = val[0];
        CFG_SCALE_STEPS: steps = val[27:0];
        default: ;
      endcase
    endfunction

    function int unsigned step_of(int unsigned k);
      return int'(steps[(k % 7) * 4 +: 4]);
    endfunction

    function logic [6:0] clip(int unsigned v);
      return (v > 127) ? 7'd127 : v[6:0];
    endfunction

    // Work out the notes caused by one accepted transaction
    function void note_input(in_item_t it);
      int unsigned trig, deg, base, r, t, n;
      out_item_t   o;
      trig = 32'(it.trigger_note);
      deg  = trig % 7;
      base = 48 + 32'(root);
      if (it.command == CMD_NOTE_ON) begin
        if (four_mode) begin
          r = base + step_of(deg);
          held_notes[trig][0] = clip(r - 12);
          held_notes[trig][1] = clip(r + step_of(deg + 4));
          held_notes[trig][2] = clip(r + 12);
          held_notes[trig][3] = clip(r + 12 + step_of(deg + 2));
          held_four[trig] = 1'b1;
        end else begin
          for (int k = 0; k < 3; k++) begin
            t = deg + 2 * k;
            held_notes[trig][k] = clip(base + step_of(t) + (t / 7) * 12);
          end
          held_notes[trig][3] = '0;
          held_four[trig] = 1'b0;
        end
        held[trig] = 1'b1;
      end else if (it.command != CMD_NOTE_OFF || !held[trig]) begin
        return;
      end
      n = held_four[trig] ? 4 : 3;
      for (int k = 0; k < n; k++) begin
        o.is_note_on    = (it.command == CMD_NOTE_ON);
        o.out_channel   = it.channel;
        o.out_note      = held_notes[trig][k];
        o.out_velocity  = it.velocity;
        o.out_position  = it.sample_position;
        o.last_of_chord = (k == n - 1);
        expected_notes = {expected_notes, o};
      end
      // a note off releases the entry
      if (it.command == CMD_NOTE_OFF) begin
        held[trig]      = 1'b0;
        held_four[trig] = 1'b0;
        for (int k = 0; k < 4; k++) held_notes[trig][k] = '0;
      end
    endfunction

    // Compare one emitted note with the oldest expected one
    function void check_note(out_item_t got);
      out_item_t exp_n;
      if (expected_notes.size() == 0) begin
        $error("unexpected note transaction: note %0d", got.out_note);
        errors++;
        return;
      end
      exp_n = expected_notes.pop_front();
      if (got.is_note_on !== exp_n.is_note_on) begin
        $error("is_note_on: expected %0d, actual %0d", exp_n.is_note_on, got.is_note_on);
        errors++;
      end
      if (got.out_channel !== exp_n.out_channel) begin
        $error("out_channel: expected %0d, actual %0d", exp_n.out_channel, got.out_channel);
        errors++;
      end
      if (got.out_note !== exp_n.out_note) begin
        $error("out_note: expected %0d, actual %0d", exp_n.out_note, got.out_note);
        errors++;
      end
      if (got.out_velocity !== exp_n.out_velocity) begin
        $error("out_velocity: expected %0d, actual %0d", exp_n.out_velocity,
               got.out_velocity);
        errors++;
      end
      if (got.out_position !== exp_n.out_position) begin
        $error("out_position: expected %0d, actual %0d", exp_n.out_position,
               got.out_position);
        errors++;
      end
      if (got.last_of_chord !== exp_n.last_of_chord) begin
        $error("last_of_chord: expected %0d, actual %0d", exp_n.last_of_chord,
               got.last_of_chord);
        errors++;
      end
    endfunction

    // A held trigger note, or -1 when none is held
    function int pick_held();
      int start;
      start = $urandom_range(0, NoteCount - 1);
      for (int i = 0; i < NoteCount; i++)
        if (held[(start + i) % NoteCount]) return (start + i) % NoteCount;
      return -1;
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  in_item_t            in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_data;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  bit                  steady = 1'b0;

  chord_tracker tracker = new();

  midi_scale_chord_expander u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  // 12-unit clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Random back-pressure on the output, none in the steady stretch
  always @(negedge clk) begin
    out_stall <= steady ? 1'b0 : ($urandom_range(0, 99) < 8);
  end

  // Check every accepted output transaction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.check_note(out_data);
  end

  // Present one message, with random gaps, until it is accepted
  task automatic send_item(in_item_t it);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < 8) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    tracker.note_input(it);
  endtask

  task automatic send(logic [1:0] cmd, logic [6:0] note, logic [4:0] ch, logic [6:0] vel,
                      logic [15:0] pos);
    in_item_t it;
    it.command         = cmd;
    it.trigger_note    = note;
    it.channel         = ch;
    it.velocity        = vel;
    it.sample_position = pos;
    send_item(it);
  endtask

  // Stop sending, let every expected note arrive, then allow for the pipeline
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.expected_notes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we   <= 1'b0;
    tracker.set_reg(idx, val);
  endtask

  task automatic set_config(logic [3:0] root, logic four, logic [27:0] steps);
    write_reg(CFG_ROOT_OFFSET, CfgDataW'(root));
    write_reg(CFG_FOUR_VOICE, CfgDataW'(four));
    write_reg(CFG_SCALE_STEPS, steps);
  endtask

  // Mostly note on / note off pairs, some other messages
  function automatic in_item_t next_event();
    in_item_t it;
    int       pick, hn;
    pick = $urandom_range(0, 99);
    it.channel         = 5'($urandom_range(0, 31));
    it.velocity        = 7'($urandom_range(0, 127));
    it.sample_position = 16'($urandom_range(0, 65535));
    it.trigger_note    = ($urandom_range(0, 99) < 60) ? 7'($urandom_range(0, 20))
                                                        : 7'($urandom_range(0, 127));
    if (pick < 45) begin
      it.command = CMD_NOTE_ON;
    end else if (pick < 85) begin
      it.command = CMD_NOTE_OFF;
      hn = tracker.pick_held();
      if (hn >= 0 && $urandom_range(0, 99) < 80) it.trigger_note = hn[6:0];
    end else begin
      it.command = (pick < 95) ? CMD_OTHER : CMD_RESERVED;
    end
    return it;
  endfunction

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, repeats and releases under the reset scale
    send(CMD_NOTE_ON,   7'd0,   5'd1,  7'd127, 16'h0000);
    send(CMD_NOTE_ON,   7'd127, 5'd16, 7'd1,   16'hFFFF);
    send(CMD_NOTE_OFF,  7'd0,   5'd1,  7'd64,  16'h1234);
    send(CMD_NOTE_OFF,  7'd0,   5'd1,  7'd64,  16'h1235);
    send(CMD_OTHER,     7'd5,   5'd2,  7'd10,  16'h0005);
    send(CMD_RESERVED,  7'd5,   5'd31, 7'd127, 16'hFFFF);
    send(CMD_NOTE_ON,   7'd60,  5'd0,  7'd0,   16'h0100);
    send(CMD_NOTE_ON,   7'd60,  5'd31, 7'd90,  16'h0200);
    send(CMD_NOTE_OFF,  7'd60,  5'd17, 7'd99,  16'h0300);
    drain();

    // Largest root and steps in four-voice mode
    set_config(4'd15, 1'b1, 28'hFFFFFFF);
    send(CMD_NOTE_ON,   7'd127, 5'd3,  7'd100, 16'h8000);
    send(CMD_NOTE_ON,   7'd6,   5'd4,  7'd50,  16'h7FFF);
    send(CMD_NOTE_OFF,  7'd127, 5'd5,  7'd0,   16'h0001);
    send(CMD_NOTE_ON,   7'd3,   5'd6,  7'd77,  16'hAAAA);
    drain();

    // Chords stored under the old setting are released unchanged
    set_config(4'd0, 1'b0, 28'h0000000);
    send(CMD_NOTE_OFF,  7'd6,   5'd7,  7'd11,  16'h5555);
    send(CMD_NOTE_ON,   7'd13,  5'd8,  7'd127, 16'h0F0F);
    send(CMD_NOTE_OFF,  7'd13,  5'd8,  7'd1,   16'hF0F0);
    send(CMD_NOTE_OFF,  7'd3,   5'd9,  7'd2,   16'h00FF);
    drain();

    // Random phases, each under its own setting; phase 2 has no idling
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_config(ROOT_RESET, 1'b0, STEPS_RESET);
        1: set_config(4'd11, 1'b1, 28'h0A86532);
        2: set_config(4'd15, 1'b1, 28'hFFFFFFF);
        3: set_config(4'd0, 1'b0, 28'h0000000);
        4: set_config(4'd7, 1'b0, 28'($urandom));
        default: set_config(4'($urandom_range(0, 15)), 1'b1, 28'($urandom));
      endcase
      steady = (p == 2);
      repeat (55) send_item(next_event());
      drain();
      steady = 1'b0;
    end

    if (tracker.errors == 0 && tracker.expected_notes.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // Watchdog
  initial begin
    #3000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
